// ----- rtl/core/http_chunked_body_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the chunked body decoder
// Concurrent checks clocked on clk; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_MACROS_SVH
`define HTTP_CHUNKED_BODY_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property outside of reset
`define CHBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property at every edge, reset included
`define CHBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CHBD_ASSERT(label, prop, msg)
`define CHBD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- rtl/core/chbd_pkg.sv -----
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types, constants and decode helpers of the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

  // Width of the chunk size counter
  localparam int SizeBits = 32;

  // Result kinds
  localparam logic [1:0] KIND_BODY     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;

  // Framing bytes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  // Bytes dropped after the data of a chunk
  localparam logic [1:0] TRAILER_BYTES = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  // Decode one ASCII hex digit, either letter case
  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t d;
    d.valid = 1'b1;
    d.value = b[3:0];
    if (b >= 8'h30 && b <= 8'h39) begin
      d.value = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      d.value = b[3:0] + 4'd9;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

  // Space, tab, LF, VT, FF and CR
  function automatic logic is_blank(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b >= CHAR_TAB && b <= CHAR_CR);
  endfunction

endpackage

// ----- rtl/core/chbd_core.sv -----
// ----------------------------------------------------------------------------
// chbd_core
// Parser state and one-byte step: size line, data countdown, trailer skip.
// ----------------------------------------------------------------------------
module chbd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  chbd_pkg::in_item_t item,
  output logic              res_valid,
  output chbd_pkg::out_item_t res
);

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_DIGITS = 3'd1,
    PH_REST   = 3'd2,
    PH_DATA   = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5,
    PH_FAULT  = 3'd6
  } phase_t;

  phase_t                        phase, phase_next;
  logic [chbd_pkg::SizeBits-1:0] chunk_remaining, chunk_remaining_next;
  logic                          digit_seen, digit_seen_next;
  logic                          previous_was_cr, previous_was_cr_next;
  logic [1:0]                    trailer_skip_count, trailer_skip_count_next;

  // Effective state after an optional restart
  phase_t                        ph;
  logic [chbd_pkg::SizeBits-1:0] cnt;
  logic                          ds;
  logic                          pcr;
  logic [1:0]                    tsc;
  logic [7:0]                    b;
  chbd_pkg::hex_digit_t          hd;
  logic                          emit;

  assign b  = item.in_byte;
  assign hd = chbd_pkg::hex_decode(b);

  // Apply the restart flag before the byte is taken
  always_comb begin
    if (item.start_of_message) begin
      ph  = PH_LEAD;
      cnt = '0;
      ds  = 1'b0;
      pcr = 1'b0;
      tsc = 2'd0;
    end else begin
      ph  = phase;
      cnt = chunk_remaining;
      ds  = digit_seen;
      pcr = previous_was_cr;
      tsc = trailer_skip_count;
    end
  end

  // Step one byte
  always_comb begin
    phase_next              = ph;
    chunk_remaining_next    = cnt;
    digit_seen_next         = ds;
    previous_was_cr_next    = pcr;
    trailer_skip_count_next = tsc;
    emit                    = 1'b0;
    res.out_byte            = 8'd0;
    res.out_kind            = chbd_pkg::KIND_BODY;
    unique case (ph)
      PH_LEAD, PH_DIGITS, PH_REST: begin
        if (b == chbd_pkg::CHAR_LF && pcr) begin
          previous_was_cr_next = 1'b0;
          if (!ds || cnt == '0) begin
            phase_next   = PH_DONE;
            emit         = 1'b1;
            res.out_kind = chbd_pkg::KIND_COMPLETE;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          previous_was_cr_next = (b == chbd_pkg::CHAR_CR);
          if (ph != PH_REST) begin
            if (hd.valid) begin
              if (cnt[chbd_pkg::SizeBits-1 -: 4] != 4'd0) begin
                phase_next   = PH_FAULT;
                emit         = 1'b1;
                res.out_kind = chbd_pkg::KIND_OVERFLOW;
              end else begin
                chunk_remaining_next = {cnt[chbd_pkg::SizeBits-5:0], hd.value};
                digit_seen_next      = 1'b1;
                phase_next           = PH_DIGITS;
              end
            end else if (!(ph == PH_LEAD && chbd_pkg::is_blank(b))) begin
              phase_next = PH_REST;
            end
          end
        end
      end
      PH_DATA: begin
        chunk_remaining_next = cnt - chbd_pkg::SizeBits'(1);
        if (cnt == chbd_pkg::SizeBits'(1)) begin
          phase_next              = PH_SKIP;
          trailer_skip_count_next = chbd_pkg::TRAILER_BYTES;
        end
        emit         = 1'b1;
        res.out_byte = b;
        res.out_kind = chbd_pkg::KIND_BODY;
      end
      PH_SKIP: begin
        trailer_skip_count_next = tsc - 2'd1;
        if (tsc == 2'd1) begin
          phase_next              = PH_LEAD;
          chunk_remaining_next    = '0;
          digit_seen_next         = 1'b0;
          previous_was_cr_next    = 1'b0;
          trailer_skip_count_next = 2'd0;
        end
      end
      default: begin
        // halted: ignore bytes until a restart
      end
    endcase
  end

  assign res_valid = go & emit;

  // Hold state; advance on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_LEAD;
      chunk_remaining    <= '0;
      digit_seen         <= 1'b0;
      previous_was_cr    <= 1'b0;
      trailer_skip_count <= 2'd0;
    end else if (go) begin
      phase              <= phase_next;
      chunk_remaining    <= chunk_remaining_next;
      digit_seen         <= digit_seen_next;
      previous_was_cr    <= previous_was_cr_next;
      trailer_skip_count <= trailer_skip_count_next;
    end
  end

`include "http_chunked_body_decoder_macros.svh"

  `CHBD_ASSERT(a_halted_silent, ((phase == PH_DONE || phase == PH_FAULT) && go && !item.start_of_message) |-> !res_valid, "halted decoder produced a result")
  `CHBD_ASSERT(a_data_nonzero, (phase == PH_DATA) |-> (chunk_remaining != '0), "data phase with zero count")
  `CHBD_ASSERT(a_skip_count, (phase == PH_SKIP) |-> (trailer_skip_count == 2'd1 || trailer_skip_count == 2'd2), "bad trailer skip count")

endmodule

// ----- rtl/core/http_chunked_body_decoder.sv -----
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes a chunked HTTP body, one raw byte per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   raw channel (raw_valid / raw_stall / raw) carries one byte of the chunked
//   stream per transaction; raw.start_of_message restarts at a new size line.
//   body channel (body_valid / body_stall / body) carries zero or one result
//   per raw byte: a body byte, a message-complete mark or a size overflow.
//   A raw byte is taken into the input register; its result is loaded into
//   the result register and presented on body when the parser steps over
//   it (go). Throughput: one byte per cycle while body_stall does not hold a
//   result; the combinational parser step between the two registers sets
//   that rate.
//   The input register refills in the same cycle its byte is consumed, and a
//   result waiting in the output register does not block the parser as long
//   as body_stall is low in that cycle.
//   While body_stall holds a result, the parser holds and raw_stall rises
//   once the input register is full.
//   Reset (rst, synchronous) empties both registers and returns the parser to
//   the start of a size line; the block takes bytes the cycle after reset.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                raw_valid,
  output logic                raw_stall,
  input  chbd_pkg::in_item_t  raw,
  output logic                body_valid,
  input  logic                body_stall,
  output chbd_pkg::out_item_t body
);

  logic                q_valid;
  chbd_pkg::in_item_t  q_item;
  logic                go;
  logic                res_valid;
  chbd_pkg::out_item_t res;

  // Consume the held byte when the result register is free or draining
  assign go        = q_valid & (~body_valid | ~body_stall);
  assign raw_stall = q_valid & ~go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!raw_stall) begin
      q_valid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!raw_stall && raw_valid) begin
      q_item <= raw;
    end
  end

  chbd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (q_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      body_valid <= 1'b0;
    end else if (go) begin
      body_valid <= res_valid;
    end else if (!body_stall) begin
      body_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      body <= res;
    end
  end

`include "http_chunked_body_decoder_macros.svh"

  `CHBD_ASSERT_ALWAYS(a_stall_needs_item, raw_stall |-> q_valid, "stall raised with empty input register")
  `CHBD_ASSERT(a_drain_clears, (body_valid && !body_stall && !go) |=> !body_valid, "taken result not cleared")
  `CHBD_ASSERT(a_hold_on_stall, (body_valid && body_stall) |-> !go, "parser advanced over a held result")

endmodule
